/* rtl/core/fci_pkg.sv */
// Shared types, constants and the divider step for the fan curve interpolator.
// No dependencies; imported by fci_divider and fan_curve_interpolator_top.
package fci_pkg;

  // Curve geometry
  localparam int MAX_POINTS = 6;
  localparam int CNT_W      = 3;
  localparam int TEMP_W     = 8;
  localparam int DUTY_W     = 8;
  localparam int POINT_W    = TEMP_W + DUTY_W;

  // Configuration register map
  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_POINT_COUNT = 3'd0;
  localparam logic [IDX_W-1:0] REG_POINT_BASE  = 3'd1;

  // Reset contents of the curve
  localparam logic [CNT_W-1:0] POINT_COUNT_RST = 3'd5;
  localparam logic [POINT_W-1:0] POINT_RST [MAX_POINTS] = '{
    16'd7680, 16'd12820, 16'd15410, 16'd18000, 16'd20580, 16'd0
  };

  // Divider geometry: product of two 8-bit values over an 8-bit span
  localparam int PROD_W    = 2 * DUTY_W;
  localparam int QUO_W     = DUTY_W;
  localparam int DIV_BITS  = 2;
  localparam int DIV_STAGES = QUO_W / DIV_BITS;

  // Segment picked by the compare stage
  typedef struct packed {
    logic                     byp;
    logic [DUTY_W-1:0]        base;
    logic [DUTY_W-1:0]        p2;
    logic signed [TEMP_W-1:0] t1;
    logic signed [TEMP_W-1:0] t2;
    logic signed [TEMP_W-1:0] x;
  } seg_t;

  // Sideband that rides along the divider
  typedef struct packed {
    logic              byp;
    logic              neg;
    logic [DUTY_W-1:0] base;
  } side_t;

  // One restoring division step: acc holds {remainder, dividend / quotient bits}
  function automatic logic [PROD_W-1:0] fci_div_step(input logic [PROD_W-1:0] acc,
                                                     input logic [DUTY_W-1:0] den);
    logic [DUTY_W:0] shifted;
    logic [DUTY_W:0] diff;
    shifted = acc[PROD_W-1:QUO_W-1];
    diff    = shifted - {1'b0, den};
    if (shifted >= {1'b0, den}) begin
      return {diff[DUTY_W-1:0], acc[QUO_W-2:0], 1'b1};
    end else begin
      return {shifted[DUTY_W-1:0], acc[QUO_W-2:0], 1'b0};
    end
  endfunction

endpackage

/* rtl/core/fan_curve_interpolator_top.sv */
// Top level of the fan curve interpolator: config registers, segment search,
// multiply, pipelined divide and output. Depends on fci_pkg and fci_divider.
//
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+--------------------------
//  request  | start_i, busy_o, temperature_i         | taken when start_i & !busy_o
//  result   | done_o, duty_o                         | one-cycle strobe, no stall
//  config   | cfg_we_i, cfg_idx_i, cfg_wdata_i       | written when cfg_we_i high
//
// A request may enter every cycle; busy_o stays low. Each request gives one
// result, registered in order by: input register, segment compare, differences,
// multiply, four divider stages of two quotient bits each, output register.
// Reset clears all valid bits and loads the default five-point curve.
// The result side cannot stall, so the pipeline always advances.
module fan_curve_interpolator_top
  import fci_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [TEMP_W-1:0]   temperature_i,
  output logic                done_o,
  output logic [DUTY_W-1:0]   duty_o,
  input  logic                cfg_we_i,
  input  logic [IDX_W-1:0]    cfg_idx_i,
  input  logic [POINT_W-1:0]  cfg_wdata_i
);

  // Configuration registers
  logic [CNT_W-1:0]   cnt_q;
  logic [POINT_W-1:0] pt_q [MAX_POINTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= POINT_COUNT_RST;
      for (int i = 0; i < MAX_POINTS; i++) begin
        pt_q[i] <= POINT_RST[i];
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_POINT_COUNT) begin
        cnt_q <= cfg_wdata_i[CNT_W-1:0];
      end
      for (int i = 0; i < MAX_POINTS; i++) begin
        if (cfg_idx_i == REG_POINT_BASE + IDX_W'(i)) begin
          pt_q[i] <= cfg_wdata_i;
        end
      end
    end
  end

  // The pipeline never holds off a request
  assign busy_o = 1'b0;

  // Stage 0: register the request
  logic                     v0_q;
  logic signed [TEMP_W-1:0] x0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q <= temperature_i;
  end

  // Stage 1: clamp the count, find the first segment holding x, pick bypasses
  logic [CNT_W-1:0]         cnt_eff;
  logic [POINT_W-1:0]       last_pt;
  logic                     found;
  logic [POINT_W-1:0]       lo_pt;
  logic [POINT_W-1:0]       hi_pt;
  seg_t                     seg_d;
  logic signed [TEMP_W-1:0] t_first;
  logic signed [TEMP_W-1:0] t_last;
  logic signed [TEMP_W-1:0] t_lo;
  logic signed [TEMP_W-1:0] t_hi;

  always_comb begin
    cnt_eff = (cnt_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : cnt_q;

    last_pt = pt_q[0];
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (CNT_W'(i + 1) == cnt_eff) begin
        last_pt = pt_q[i];
      end
    end

    found = 1'b0;
    lo_pt = pt_q[0];
    hi_pt = pt_q[0];
    for (int i = 0; i < MAX_POINTS - 1; i++) begin
      if (!found && (CNT_W'(i + 2) <= cnt_eff)
          && (x0_q >= $signed(pt_q[i][POINT_W-1:DUTY_W]))
          && (x0_q <= $signed(pt_q[i+1][POINT_W-1:DUTY_W]))) begin
        found = 1'b1;
        lo_pt = pt_q[i];
        hi_pt = pt_q[i+1];
      end
    end

    t_first = $signed(pt_q[0][POINT_W-1:DUTY_W]);
    t_last  = $signed(last_pt[POINT_W-1:DUTY_W]);
    t_lo    = $signed(lo_pt[POINT_W-1:DUTY_W]);
    t_hi    = $signed(hi_pt[POINT_W-1:DUTY_W]);

    seg_d.p2 = hi_pt[DUTY_W-1:0];
    seg_d.t1 = t_lo;
    seg_d.t2 = t_hi;
    seg_d.x  = x0_q;
    if (cnt_eff == '0) begin
      seg_d.byp  = 1'b1;
      seg_d.base = '0;
    end else if (x0_q <= t_first) begin
      seg_d.byp  = 1'b1;
      seg_d.base = pt_q[0][DUTY_W-1:0];
    end else if (x0_q >= t_last) begin
      seg_d.byp  = 1'b1;
      seg_d.base = last_pt[DUTY_W-1:0];
    end else if (!found) begin
      seg_d.byp  = 1'b1;
      seg_d.base = '0;
    end else begin
      // Flat segment falls back to its first duty
      seg_d.byp  = (t_lo == t_hi);
      seg_d.base = lo_pt[DUTY_W-1:0];
    end
  end

  logic v1_q;
  seg_t seg1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    seg1_q <= seg_d;
  end

  // Stage 2: duty span magnitude, offset into the segment and its width
  logic [DUTY_W:0]   dp_w;
  logic              neg_w;
  logic [DUTY_W-1:0] dmag_w;
  logic [TEMP_W:0]   dx_w;
  logic [TEMP_W:0]   den_w;

  always_comb begin
    dp_w   = {1'b0, seg1_q.p2} - {1'b0, seg1_q.base};
    neg_w  = seg1_q.p2 < seg1_q.base;
    dmag_w = neg_w ? (seg1_q.base - seg1_q.p2) : dp_w[DUTY_W-1:0];
    dx_w   = {seg1_q.x[TEMP_W-1], seg1_q.x} - {seg1_q.t1[TEMP_W-1], seg1_q.t1};
    den_w  = {seg1_q.t2[TEMP_W-1], seg1_q.t2} - {seg1_q.t1[TEMP_W-1], seg1_q.t1};
  end

  logic              v2_q;
  side_t             side2_q;
  logic [DUTY_W-1:0] dmag2_q;
  logic [TEMP_W-1:0] dx2_q;
  logic [TEMP_W-1:0] den2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side2_q.byp  <= seg1_q.byp;
    side2_q.neg  <= neg_w;
    side2_q.base <= seg1_q.base;
    dmag2_q      <= dmag_w;
    dx2_q        <= dx_w[TEMP_W-1:0];
    den2_q       <= den_w[TEMP_W-1:0];
  end

  // Stage 3: multiply span by offset
  logic              v3_q;
  side_t             side3_q;
  logic [PROD_W-1:0] prod3_q;
  logic [DUTY_W-1:0] den3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side3_q <= side2_q;
    prod3_q <= dmag2_q * dx2_q;
    den3_q  <= den2_q;
  end

  // Divide product by segment width
  logic              dv_valid;
  logic [QUO_W-1:0]  dv_quo;
  logic              dv_rem_nz;
  side_t             dv_side;

  fci_divider u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (v3_q),
    .in_num_i     (prod3_q),
    .in_den_i     (den3_q),
    .in_side_i    (side3_q),
    .out_valid_o  (dv_valid),
    .out_quo_o    (dv_quo),
    .out_rem_nz_o (dv_rem_nz),
    .out_side_o   (dv_side)
  );

  // Output stage: apply the step, flooring toward minus infinity when falling
  logic [DUTY_W-1:0] duty_d;

  always_comb begin
    if (dv_side.byp) begin
      duty_d = dv_side.base;
    end else if (dv_side.neg) begin
      duty_d = dv_side.base - dv_quo - DUTY_W'(dv_rem_nz);
    end else begin
      duty_d = dv_side.base + dv_quo;
    end
  end

  logic              done_q;
  logic [DUTY_W-1:0] duty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    duty_q <= duty_d;
  end

  assign done_o = done_q;
  assign duty_o = duty_q;

endmodule

/* rtl/core/fci_divider.sv */
// Pipelined restoring divider, DIV_BITS quotient bits per stage.
// Depends on fci_pkg for widths, sideband type and the step function.
module fci_divider
  import fci_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [PROD_W-1:0]   in_num_i,
  input  logic [DUTY_W-1:0]   in_den_i,
  input  side_t               in_side_i,
  output logic                out_valid_o,
  output logic [QUO_W-1:0]    out_quo_o,
  output logic                out_rem_nz_o,
  output side_t               out_side_o
);

  logic              vld_q  [DIV_STAGES];
  logic [PROD_W-1:0] acc_q  [DIV_STAGES];
  logic [DUTY_W-1:0] den_q  [DIV_STAGES];
  side_t             side_q [DIV_STAGES];

  logic [PROD_W-1:0] acc_in  [DIV_STAGES];
  logic [DUTY_W-1:0] den_in  [DIV_STAGES];
  side_t             side_in [DIV_STAGES];
  logic              vld_in  [DIV_STAGES];
  logic [PROD_W-1:0] acc_d   [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    // Pick the stage input: the ports for the first stage, else the stage before
    if (s == 0) begin : g_first
      assign acc_in[s]  = in_num_i;
      assign den_in[s]  = in_den_i;
      assign side_in[s] = in_side_i;
      assign vld_in[s]  = in_valid_i;
    end else begin : g_next
      assign acc_in[s]  = acc_q[s-1];
      assign den_in[s]  = den_q[s-1];
      assign side_in[s] = side_q[s-1];
      assign vld_in[s]  = vld_q[s-1];
    end

    // Resolve DIV_BITS quotient bits
    always_comb begin
      acc_d[s] = acc_in[s];
      for (int b = 0; b < DIV_BITS; b++) begin
        acc_d[s] = fci_div_step(acc_d[s], den_in[s]);
      end
    end

    // Advance the valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in[s];
      end
    end

    // Advance the payload
    always_ff @(posedge clk_i) begin
      acc_q[s]  <= acc_d[s];
      den_q[s]  <= den_in[s];
      side_q[s] <= side_in[s];
    end
  end

  assign out_valid_o  = vld_q[DIV_STAGES-1];
  assign out_quo_o    = acc_q[DIV_STAGES-1][QUO_W-1:0];
  assign out_rem_nz_o = |acc_q[DIV_STAGES-1][PROD_W-1:QUO_W];
  assign out_side_o   = side_q[DIV_STAGES-1];

endmodule
